// ----- rtl/core/utf8_to_utf32_decoder_assert.svh -----
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_UTF32_DECODER_ASSERT_SVH
`define UTF8_TO_UTF32_DECODER_ASSERT_SVH

// same-cycle implication, off during reset
`define U8DEC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("u8dec assertion failed");

// next-cycle implication, off during reset
`define U8DEC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("u8dec assertion failed");

// next-cycle implication, checked through reset as well
`define U8DEC_ASSERT_NEXT_ALWAYS(label, clk, lhs, rhs) \
    label: assert property (@(posedge clk) (lhs) |=> (rhs)) \
        else $error("u8dec assertion failed");

`endif

// ----- rtl/core/u8dec_pkg.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Widths, status codes and state types shared by the decoder files.
// ----------------------------------------------------------------------------
package u8dec_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 21;
    localparam int CNT_W  = 3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ILLEGAL   = 2'd1,
        ST_TRUNCATED = 2'd2
    } t_status;

    typedef struct packed {
        logic [CNT_W-1:0]  bytes_left;
        logic [CP_W-1:0]   acc;
        logic [BYTE_W-1:0] lead;
        logic [CNT_W-1:0]  seen;
        logic              bad;
        logic              discarding;
    } t_state;

    typedef struct packed {
        logic            emit;
        logic [CP_W-1:0] code_point;
        t_status         status;
        logic            final_result;
    } t_result;

endpackage

// ----- rtl/core/u8dec_if.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder channels
// Valid/ready channels for input bytes and decoded code points.
// ----------------------------------------------------------------------------
interface u8dec_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface u8dec_out_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        final_result;

    modport source (output valid, output code_point, output status, output final_result,
                    input ready);
    modport sink   (input valid, input code_point, input status, input final_result,
                    output ready);
endinterface

// ----- rtl/core/u8dec_step.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder step
// Next sequence state and optional result for one byte.
// ----------------------------------------------------------------------------
module u8dec_step (
    input  u8dec_pkg::t_state  i_state,
    input  logic [7:0]         i_byte,
    input  logic               i_end,
    output u8dec_pkg::t_state  o_state,
    output u8dec_pkg::t_result o_res
);
    import u8dec_pkg::*;

    logic [CNT_W-1:0]  trail_cnt;
    logic [BYTE_W-1:0] lead_mask;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic              trail_ok;
    logic              done;
    t_state            st;
    t_result           res;

    always_comb begin
        if (i_byte < 8'hC0) begin
            trail_cnt = 3'd0;
        end else if (i_byte < 8'hE0) begin
            trail_cnt = 3'd1;
        end else if (i_byte < 8'hF0) begin
            trail_cnt = 3'd2;
        end else if (i_byte < 8'hF8) begin
            trail_cnt = 3'd3;
        end else if (i_byte < 8'hFC) begin
            trail_cnt = 3'd4;
        end else begin
            trail_cnt = 3'd5;
        end
    end

    always_comb begin
        case (trail_cnt)
            3'd0:    lead_mask = 8'h7F;
            3'd1:    lead_mask = 8'h3F;
            3'd2:    lead_mask = 8'h1F;
            3'd3:    lead_mask = 8'h0F;
            3'd4:    lead_mask = 8'h07;
            default: lead_mask = 8'h03;
        endcase
    end

    always_comb begin
        lo = 8'h80;
        hi = 8'hBF;
        if (i_state.seen == 3'd0) begin
            case (i_state.lead)
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
            endcase
        end
        trail_ok = (i_byte >= lo) && (i_byte <= hi);
    end

    always_comb begin
        st   = i_state;
        res  = '0;
        done = 1'b0;
        if (i_state.discarding) begin
            if (i_end) begin
                st = '0;
            end
        end else begin
            if (i_state.bytes_left == 3'd0) begin
                st.lead       = i_byte;
                st.seen       = 3'd0;
                st.bad        = ((i_byte >= 8'h80) && (i_byte < 8'hC2)) || (i_byte > 8'hF4);
                st.acc        = {{(CP_W-BYTE_W){1'b0}}, i_byte & lead_mask};
                st.bytes_left = trail_cnt;
                done          = (trail_cnt == 3'd0);
            end else begin
                st.bad        = i_state.bad | ~trail_ok;
                st.acc        = {i_state.acc[CP_W-7:0], i_byte[5:0]};
                st.seen       = i_state.seen + 3'd1;
                st.bytes_left = i_state.bytes_left - 3'd1;
                done          = (st.bytes_left == 3'd0);
            end
            if (!done) begin
                if (i_end) begin
                    res.emit         = 1'b1;
                    res.status       = ST_TRUNCATED;
                    res.final_result = 1'b1;
                    st               = '0;
                end
            end else begin
                res.emit         = 1'b1;
                res.status       = st.bad ? ST_ILLEGAL : ST_OK;
                res.code_point   = st.bad ? '0 : st.acc;
                res.final_result = i_end;
                st               = '0;
                st.discarding    = i_state.bad | (i_state.bytes_left == 3'd0 ?
                                   (((i_byte >= 8'h80) && (i_byte < 8'hC2)) || (i_byte > 8'hF4))
                                   : ~trail_ok);
                st.discarding    = st.discarding & ~i_end;
            end
        end
    end

    assign o_state = st;
    assign o_res   = res;

endmodule

// ----- rtl/core/utf8_to_utf32_decoder.sv -----
// ----------------------------------------------------------------------------
// UTF-8 to UTF-32 decoder
// Strict UTF-8 stream decoder, one byte per word in, one code point out.
//
//   channel  dir  payload                              role
//   i_byte   in   data_byte[7:0], stream_end           raw UTF-8 bytes
//   o_cp     out  code_point[20:0], status[1:0],       decoded results
//                 final_result
//
// One byte per clock sustained while the result channel is not stalled; each byte
// passes through the input register and is decoded into the result register.
// Reset clears sequence state and both valid flags; no clearing pass.
// A stalled result holds the decode stage; the input register fills only while empty.
// ----------------------------------------------------------------------------
module utf8_to_utf32_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8dec_in_if.sink    i_byte,
    u8dec_out_if.source o_cp
);
    import u8dec_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_end;
    t_state            r_state;
    t_state            n_state;
    t_result           n_res;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_out_cp;
    t_status           r_out_status;
    logic              r_out_final;
    logic              out_free;
    logic              fire;

    assign out_free     = !r_out_valid || o_cp.ready;
    assign fire         = r_in_valid && out_free;
    assign i_byte.ready = !r_in_valid || fire;

    u8dec_step u_step (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_end   (r_in_end),
        .o_state (n_state),
        .o_res   (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_in_valid <= i_byte.valid;
            end
            if (fire) begin
                r_state <= n_state;
            end
            if (out_free) begin
                r_out_valid <= fire && n_res.emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_end  <= i_byte.stream_end;
        end
        if (fire && n_res.emit) begin
            r_out_cp     <= n_res.code_point;
            r_out_status <= n_res.status;
            r_out_final  <= n_res.final_result;
        end
    end

    assign o_cp.valid        = r_out_valid;
    assign o_cp.code_point   = r_out_cp;
    assign o_cp.status       = r_out_status;
    assign o_cp.final_result = r_out_final;

endmodule

// ----- rtl/core/u8dec_chk.sv -----
// ----------------------------------------------------------------------------
// UTF-8 decoder checker
// Port-level checks on the decoder's result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_to_utf32_decoder_assert.svh"

module u8dec_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [20:0] i_code_point,
    input logic [1:0]  i_status,
    input logic        i_final_result
);
    import u8dec_pkg::*;

    `U8DEC_ASSERT_IMPLY(a_err_zero_cp, i_clk, i_rst_n,
        i_out_valid && (i_status != ST_OK), i_code_point == '0)
    `U8DEC_ASSERT_IMPLY(a_trunc_final, i_clk, i_rst_n,
        i_out_valid && (i_status == ST_TRUNCATED), i_final_result)
    `U8DEC_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready,
        i_out_valid && $stable(i_code_point) && $stable(i_status) && $stable(i_final_result))
    `U8DEC_ASSERT_NEXT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind utf8_to_utf32_decoder u8dec_chk u_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_cp.valid),
    .i_out_ready    (o_cp.ready),
    .i_code_point   (o_cp.code_point),
    .i_status       (o_cp.status),
    .i_final_result (o_cp.final_result)
);
